// ===== design/four_axis_step_dir_pulse_generator_macros.svh =====
// Assertion macros shared by the step/direction pulse generator RTL.
`ifndef FOUR_AXIS_STEP_DIR_PULSE_GENERATOR_MACROS_SVH
`define FOUR_AXIS_STEP_DIR_PULSE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define SDPG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdpg assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SDPG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdpg assertion failed");

`else

`define SDPG_ASSERT_IMP(label, clk, rst, ante, cons)
`define SDPG_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/sdpg_pkg.sv =====
// Package with the constants, state type and control structs of the pulse generator.
package sdpg_pkg;

  localparam int NUM_MOTORS   = 4;
  localparam int NUM_DIV_REGS = 4;
  localparam int MOTOR_IDX_W  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int CFG_IDX_W    = $clog2(NUM_DIV_REGS);
  localparam int DIV_W        = 16;
  localparam int POS_W        = 32;
  localparam int CNT_W        = 32;
  localparam int STEPS_W      = 31;
  localparam int ID_W         = 2;
  localparam int PIN_W        = 4;
  localparam int LEVEL_W      = (NUM_MOTORS > PIN_W) ? NUM_MOTORS : PIN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_STEP,
    ST_FINISH
  } sdpg_state_t;

  typedef struct packed {
    logic                   load_input;
    logic                   do_move;
    logic                   tick_inc;
    logic                   div_start;
    logic                   apply_step;
    logic                   load_output;
    logic [MOTOR_IDX_W-1:0] motor;
  } sdpg_cmd_t;

  typedef struct packed {
    logic op_move;
    logic motor_enabled;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sdpg_status_t;

endpackage

// ===== design/four_axis_step_dir_pulse_generator.sv =====
// Top level of the four-channel step/direction pulse generator.
// Usage: the input channel (in_valid, in_stall) carries one word per timer tick
// (operation 0) or per move command (operation 1, with motor_id and steps). A
// move clears that motor's position and sets its target to twice steps. A tick
// advances the 32-bit tick counter and steps each enabled motor whose divider
// divides the counter, toward its target. Every word yields one result word on
// the output channel (out_valid, out_stall): step_pins, dir_pins, moving_mask.
// Dividers are written through cfg_write, cfg_index and cfg_data while idle.
// The block works on one word at a time. A move goes from the dispatch state
// to the finish state, where its result is loaded once the output is free. A
// tick visits the motors in turn and, for each one with a nonzero divider,
// runs the single shared divider, which resolves one quotient bit per cycle
// and sets how long a tick takes. The next word can be accepted in the cycle
// after the result is loaded.
// The block takes the next word while a finished result still waits on a stall;
// it holds in_stall only while it works on a word or cannot yet hand off its
// result. A stalled result word holds its value until taken.
// Reset (rst, synchronous) clears counter, positions, targets, step levels and
// dividers, sets all direction levels to reverse and empties the output.
`include "four_axis_step_dir_pulse_generator_macros.svh"

module four_axis_step_dir_pulse_generator
  import sdpg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic [ID_W-1:0]           motor_id,
  input  logic signed [STEPS_W-1:0] steps,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PIN_W-1:0]          step_pins,
  output logic [PIN_W-1:0]          dir_pins,
  output logic [PIN_W-1:0]          moving_mask,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIV_W-1:0]          cfg_data
);

  sdpg_cmd_t    cmd;
  sdpg_status_t status;

  // The controller owns sequencing and the motor counter; all other state lives
  // in the datapath.
  sdpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sdpg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (operation),
    .motor_id    (motor_id),
    .steps       (steps),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .step_pins   (step_pins),
    .dir_pins    (dir_pins),
    .moving_mask (moving_mask)
  );

  // An accepted word keeps the input stalled while it is worked on.
  `SDPG_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // A result is never loaded over one that is still stalled.
  `SDPG_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load_output, !out_valid || !out_stall)
  // The shared divider is only started when it is free.
  `SDPG_ASSERT_IMP(a_div_free, clk, rst, cmd.div_start, !status.div_busy)
  // A motor update uses a quotient and remainder that have just finished.
  `SDPG_ASSERT_IMP(a_step_after_div, clk, rst, cmd.apply_step, $past(status.div_done))

endmodule

// ===== design/sdpg_div.sv =====
// Iterative restoring divider: tick count by a 16-bit divider, one quotient bit a cycle.
module sdpg_div
  import sdpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic             quo_lsb,
  output logic             rem_zero
);

  localparam int ITER_W = $clog2(CNT_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CNT_W - 1);

  logic [DIV_W-1:0]  rem;
  logic [CNT_W-1:0]  quo;
  logic [DIV_W-1:0]  dvs;
  logic [ITER_W-1:0] count;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              fits;

  // The remainder stays below the divisor, so the shifted value is below twice
  // the divisor and the top bit of the difference is a clean borrow flag.
  assign shifted = {rem, quo[CNT_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == ITER_LAST);
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == ITER_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo <= {quo[CNT_W-2:0], fits};
    end
  end

  assign quo_lsb  = quo[0];
  assign rem_zero = (rem == '0);

endmodule

// ===== design/sdpg_datapath.sv =====
// Datapath: motor state, divider registers, shared divider and output register.
module sdpg_datapath
  import sdpg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  sdpg_cmd_t                 cmd,
  output sdpg_status_t              status,
  input  logic                      operation,
  input  logic [ID_W-1:0]           motor_id,
  input  logic signed [STEPS_W-1:0] steps,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIV_W-1:0]          cfg_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PIN_W-1:0]          step_pins,
  output logic [PIN_W-1:0]          dir_pins,
  output logic [PIN_W-1:0]          moving_mask
);

  localparam logic [LEVEL_W-1:0] DIR_RESET = LEVEL_W'((64'd1 << NUM_MOTORS) - 64'd1);

  logic                      op_q;
  logic [ID_W-1:0]           id_q;
  logic signed [STEPS_W-1:0] steps_q;

  logic [CNT_W-1:0]         tick_count;
  logic signed [POS_W-1:0]  position [NUM_MOTORS];
  logic signed [POS_W-1:0]  target_position [NUM_MOTORS];
  logic [LEVEL_W-1:0]       step_level;
  logic [LEVEL_W-1:0]       dir_level;
  logic [DIV_W-1:0]         div_reg [NUM_DIV_REGS];

  logic [DIV_W-1:0]         cur_div;
  logic signed [POS_W-1:0]  cur_pos;
  logic signed [POS_W-1:0]  cur_tgt;
  logic                     below;
  logic                     above;
  logic                     div_busy;
  logic                     div_done;
  logic                     quo_lsb;
  logic                     rem_zero;
  logic [LEVEL_W-1:0]       moving;
  logic                     move_ok;

  always_comb begin
    cur_div = '0;
    if (32'(cmd.motor) < NUM_DIV_REGS) begin
      cur_div = div_reg[CFG_IDX_W'(cmd.motor)];
    end
  end

  assign cur_pos = position[cmd.motor];
  assign cur_tgt = target_position[cmd.motor];
  assign below   = cur_pos < cur_tgt;
  assign above   = cur_pos > cur_tgt;
  assign move_ok = 32'(id_q) < NUM_MOTORS;

  sdpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tick_count),
    .divisor  (cur_div),
    .busy     (div_busy),
    .done     (div_done),
    .quo_lsb  (quo_lsb),
    .rem_zero (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      op_q    <= operation;
      id_q    <= motor_id;
      steps_q <= steps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      step_level <= '0;
      dir_level  <= DIR_RESET;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        position[m]        <= '0;
        target_position[m] <= '0;
      end
      for (int r = 0; r < NUM_DIV_REGS; r++) begin
        div_reg[r] <= '0;
      end
    end else begin
      if (cfg_write && (32'(cfg_index) < NUM_MOTORS)) begin
        div_reg[cfg_index] <= cfg_data;
      end
      if (cmd.tick_inc) begin
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.do_move && move_ok) begin
        // Each full step is two half-periods of the step pin.
        position[MOTOR_IDX_W'(id_q)]        <= '0;
        target_position[MOTOR_IDX_W'(id_q)] <= {steps_q, 1'b0};
      end
      if (cmd.apply_step && rem_zero && (below || above)) begin
        dir_level[cmd.motor]  <= above;
        step_level[cmd.motor] <= quo_lsb;
        position[cmd.motor]   <= below ? cur_pos + POS_W'(1) : cur_pos - POS_W'(1);
      end
    end
  end

  always_comb begin
    moving = '0;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      moving[m] = position[m] != target_position[m];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_output) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_output) begin
      step_pins   <= step_level[PIN_W-1:0];
      dir_pins    <= dir_level[PIN_W-1:0];
      moving_mask <= moving[PIN_W-1:0];
    end
  end

  assign status.op_move       = op_q;
  assign status.motor_enabled = cur_div != '0;
  assign status.div_busy      = div_busy;
  assign status.div_done      = div_done;
  assign status.out_free      = !out_valid || !out_stall;

endmodule

// ===== design/sdpg_ctrl.sv =====
// Controller: sequences one word through the motors and the shared divider.
module sdpg_ctrl
  import sdpg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  sdpg_status_t status,
  output sdpg_cmd_t    cmd
);

  localparam logic [MOTOR_IDX_W-1:0] MOTOR_LAST = MOTOR_IDX_W'(NUM_MOTORS - 1);

  sdpg_state_t            state;
  sdpg_state_t            state_next;
  logic [MOTOR_IDX_W-1:0] motor;
  logic [MOTOR_IDX_W-1:0] motor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      motor <= '0;
    end else begin
      state <= state_next;
      motor <= motor_next;
    end
  end

  always_comb begin
    state_next = state;
    motor_next = motor;
    cmd        = '0;
    cmd.motor  = motor;
    in_stall   = state != ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_input = 1'b1;
          state_next     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        motor_next = '0;
        if (status.op_move) begin
          cmd.do_move = 1'b1;
          state_next  = ST_FINISH;
        end else begin
          cmd.tick_inc = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.motor_enabled) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV_WAIT;
        end else if (motor == MOTOR_LAST) begin
          state_next = ST_FINISH;
        end else begin
          motor_next = motor + 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.apply_step = 1'b1;
        if (motor == MOTOR_LAST) begin
          state_next = ST_FINISH;
        end else begin
          motor_next = motor + 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_output = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the four-axis step/direction pulse generator.
module tb_top;
  import sdpg_pkg::*;

  // Percent idle chance per receiver cycle and per sent word, except when steady.
  localparam int IDLE_PERCENT   = 18;
  // The slowest word is a tick with all four motors enabled. Stalls, drain
  // pauses and register writes add far less, so the limit is generous.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last result, so that a stray extra word shows up.
  localparam int SETTLE_CYCLES  = 200;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } op_t;

  // Divider register i belongs to motor i.
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_MOTOR0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_MOTOR1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_MOTOR2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_MOTOR3 = CFG_IDX_W'(3);

  localparam logic signed [STEPS_W-1:0] STEPS_MAX = {1'b0, {(STEPS_W-1){1'b1}}};
  localparam logic signed [STEPS_W-1:0] STEPS_MIN = {1'b1, {(STEPS_W-1){1'b0}}};

  typedef struct packed {
    logic [PIN_W-1:0] step_pins;
    logic [PIN_W-1:0] dir_pins;
    logic [PIN_W-1:0] moving_mask;
  } pin_word_t;

  // Tracks the motion state of all motors and keeps the pin words that the
  // block still owes, oldest first.
  class pin_scoreboard;
    logic [CNT_W-1:0]        tick_count;
    logic signed [POS_W-1:0] position [NUM_MOTORS];
    logic signed [POS_W-1:0] target   [NUM_MOTORS];
    logic [DIV_W-1:0]        divider  [NUM_MOTORS];
    logic [PIN_W-1:0]        step_level;
    logic [PIN_W-1:0]        dir_level;
    pin_word_t               owed_pins [$];
    int                      errors;

    function new();
      tick_count = '0;
      step_level = '0;
      dir_level  = '1;
      errors     = 0;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        position[m] = '0;
        target[m]   = '0;
        divider[m]  = '0;
      end
    endfunction

    function void set_divider(int motor, logic [DIV_W-1:0] value);
      divider[motor] = value;
    endfunction

    // Advances the motion state by one accepted input word and queues the
    // pin word that the block must answer with.
    function void note_word(op_t op, logic [ID_W-1:0] id, logic signed [STEPS_W-1:0] count);
      logic [CNT_W-1:0] div;
      logic [CNT_W-1:0] quot;
      pin_word_t        w;
      if (op == OP_MOVE) begin
        if (id < NUM_MOTORS) begin
          position[id] = '0;
          // Every full step is two half-periods of the step pin.
          target[id] = $signed({count, 1'b0});
        end
      end else begin
        tick_count = tick_count + 1'b1;
        for (int m = 0; m < NUM_MOTORS; m++) begin
          div = CNT_W'(divider[m]);
          if (div != 0 && (tick_count % div) == 0) begin
            quot = tick_count / div;
            if (position[m] < target[m]) begin
              dir_level[m]  = 1'b0;
              step_level[m] = quot[0];
              position[m]   = position[m] + 1;
            end else if (position[m] > target[m]) begin
              dir_level[m]  = 1'b1;
              step_level[m] = quot[0];
              position[m]   = position[m] - 1;
            end
          end
        end
      end
      w.step_pins = step_level;
      w.dir_pins  = dir_level;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        w.moving_mask[m] = (position[m] != target[m]);
      end
      owed_pins.push_back(w);
    endfunction

    function void compare_field(string name, logic [PIN_W-1:0] want, logic [PIN_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(pin_word_t got);
      pin_word_t want;
      if (owed_pins.size() == 0) begin
        $display("%0t: result word with none expected, step %h dir %h moving %h",
                 $time, got.step_pins, got.dir_pins, got.moving_mask);
        errors++;
        return;
      end
      want = owed_pins.pop_front();
      compare_field("step_pins", want.step_pins, got.step_pins);
      compare_field("dir_pins", want.dir_pins, got.dir_pins);
      compare_field("moving_mask", want.moving_mask, got.moving_mask);
    endfunction

    function int pending();
      return owed_pins.size();
    endfunction
  endclass

  // All block inputs start at known values before the first edge.
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      operation = 1'b0;
  logic [ID_W-1:0]           motor_id = '0;
  logic signed [STEPS_W-1:0] steps = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [PIN_W-1:0]          step_pins;
  logic [PIN_W-1:0]          dir_pins;
  logic [PIN_W-1:0]          moving_mask;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [DIV_W-1:0]          cfg_data = '0;

  // While set, neither side idles; one phase of the run uses this.
  logic steady = 1'b0;
  int   quiet_cycles = 0;

  pin_scoreboard sb;

  four_axis_step_dir_pulse_generator uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .motor_id   (motor_id),
    .steps      (steps),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .step_pins  (step_pins),
    .dir_pins   (dir_pins),
    .moving_mask(moving_mask),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver stalls at random. Stall is a free choice of the receiving
  // side, so it may change while a result word is waiting.
  always @(posedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Every signal read here changes only in the nonblocking update of an edge,
  // so the values seen are the ones that decided the handshake at this edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_word({step_pins, dir_pins, moving_mask});
    end
  end

  // The run is stuck if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one word and returns at the edge that accepts it. Valid stays high
  // on return, so back-to-back words never lower and raise it in one step.
  task automatic send_word(op_t op, logic [ID_W-1:0] id, logic signed [STEPS_W-1:0] count);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    motor_id  <= id;
    steps     <= count;
    do @(posedge clk); while (in_stall);
    sb.note_word(op, id, count);
  endtask

  // Holds the input off until every owed result has come back, then waits on
  // so the block is surely idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the enable is left high for the caller to lower.
  task automatic put_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIV_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_divider(int'(idx), value);
  endtask

  // Dividers are only rewritten once the block has gone idle.
  task automatic apply_dividers(logic [DIV_W-1:0] d0, logic [DIV_W-1:0] d1,
                                logic [DIV_W-1:0] d2, logic [DIV_W-1:0] d3);
    wait_drained();
    put_cfg(REG_DIVIDER_MOTOR0, d0);
    put_cfg(REG_DIVIDER_MOTOR1, d1);
    put_cfg(REG_DIVIDER_MOTOR2, d2);
    put_cfg(REG_DIVIDER_MOTOR3, d3);
    cfg_write <= 1'b0;
  endtask

  // Move sizes: mostly short moves that finish within a run of ticks, some
  // fully random counts so every bit of the field toggles, the limits, zero and -1.
  function automatic logic signed [STEPS_W-1:0] pick_steps();
    int roll;
    int amount;
    roll = $urandom_range(99);
    if (roll < 60) begin
      amount = int'($urandom_range(12)) - 6;
      return STEPS_W'(amount);
    end else if (roll < 75) begin
      amount = int'($urandom_range(200)) - 100;
      return STEPS_W'(amount);
    end else if (roll < 90) begin
      return STEPS_W'($urandom());
    end
    case ($urandom_range(3))
      0: return STEPS_MAX;
      1: return STEPS_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Most traffic is a move followed by a run of ticks, which is what makes a
  // motor actually walk toward its target. The rest is loose words of either
  // kind, plus the odd full drain of the pipeline.
  task automatic random_traffic(int word_count);
    int sent;
    int roll;
    int run;
    sent = 0;
    while (sent < word_count) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        send_word(OP_MOVE, ID_W'($urandom_range(NUM_MOTORS - 1)), pick_steps());
        run = $urandom_range(1, 30);
        // The id and count of a tick are ignored, so they carry noise.
        repeat (run) send_word(OP_TICK, ID_W'($urandom()), STEPS_W'($urandom()));
        sent += run + 1;
      end else if (roll < 98) begin
        send_word(op_t'($urandom_range(1)), ID_W'($urandom()), STEPS_W'($urandom()));
        sent++;
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // All dividers are zero after reset: ticks must leave the pins alone
    // while the moves below only change the moving mask.
    send_word(OP_TICK, 2'd0, '0);
    send_word(OP_MOVE, 2'd0, STEPS_MAX);
    send_word(OP_MOVE, 2'd1, STEPS_MIN);
    send_word(OP_MOVE, 2'd2, '0);
    send_word(OP_MOVE, 2'd3, '1);
    send_word(OP_TICK, 2'd3, STEPS_MAX);
    send_word(OP_TICK, 2'd1, STEPS_MIN);

    // Distinct dividers: each motor steps at its own rate, in both directions,
    // and a motor with a zero-length move stays put.
    apply_dividers(16'd1, 16'd2, 16'd3, 16'd4);
    send_word(OP_MOVE, 2'd0, 31'sd2);
    send_word(OP_MOVE, 2'd1, -31'sd2);
    send_word(OP_MOVE, 2'd2, 31'sd1);
    send_word(OP_MOVE, 2'd3, -31'sd1);
    repeat (12) send_word(OP_TICK, 2'd0, '0);
    send_word(OP_MOVE, 2'd0, '0);
    send_word(OP_TICK, 2'd2, '0);
    random_traffic(200);

    // A long stretch with no idling on either side.
    apply_dividers(16'd1, 16'd1, 16'd1, 16'd1);
    steady <= 1'b1;
    random_traffic(220);
    steady <= 1'b0;

    // Largest and zero divider side by side.
    apply_dividers(16'hFFFF, 16'd0, 16'd7, 16'd1);
    random_traffic(200);

    // Every motor disabled: only the moving mask may change.
    apply_dividers(16'd0, 16'd0, 16'd0, 16'd0);
    random_traffic(150);

    apply_dividers(DIV_W'($urandom_range(1, 6)), DIV_W'($urandom_range(0, 6)),
                   DIV_W'($urandom()), DIV_W'($urandom_range(1, 3)));
    random_traffic(250);

    apply_dividers(16'd2, 16'hFFFF, 16'd1, 16'd3);
    random_traffic(200);

    // All dividers at the top: every tick is the slowest case, so keep it short.
    apply_dividers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_traffic(40);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/sdpg_pkg.sv
design/sdpg_div.sv
design/sdpg_datapath.sv
design/sdpg_ctrl.sv
design/four_axis_step_dir_pulse_generator.sv
dv/tb_top.sv
